// ----- rtl/hbp_pkg.sv -----
package hbp_pkg;

   localparam int BYTE_BITS   = 8;
   localparam int CODE_BITS   = 32;
   localparam int LENGTH_BITS = 6;
   localparam int CMD_BITS    = 2;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_ENCODE = 2'd1,
      CMD_FINISH = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [CMD_BITS-1:0]    cmd;
      logic [7:0]             symbol;
      logic [CODE_BITS-1:0]   code_value;
      logic [LENGTH_BITS-1:0] code_length;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic                 is_pad_count;
      logic                 last;
   } rsp_payload_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic in_range;
   } tbl_ctrl_type;

endpackage

// ----- rtl/hbp_stream_if.sv -----
interface hbp_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/hbp_code_table.sv -----
module hbp_code_table import hbp_pkg::*; #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8,
   parameter int CODE_W = 32,
   parameter int LEN_W  = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  tbl_ctrl_type      ctrl,
   input  logic [ADDR_W-1:0] addr,
   input  logic [CODE_W-1:0] wr_value,
   input  logic [LEN_W-1:0]  wr_length,
   output logic [CODE_W-1:0] rd_value,
   output logic [LEN_W-1:0]  rd_length
);

   logic [CODE_W+LEN_W-1:0] mem [DEPTH];
   logic [CODE_W+LEN_W-1:0] rd_data_ff;
   logic [DEPTH-1:0]        valid_ff;
   logic                    rd_hit_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en && ctrl.in_range) begin
         mem[addr] <= {wr_value, wr_length};
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (ctrl.wr_en && ctrl.in_range) begin
            valid_ff[addr] <= 1'b1;
         end
         if (ctrl.rd_en) begin
            rd_hit_ff <= ctrl.in_range && valid_ff[addr];
         end
      end
   end

   assign rd_value  = rd_hit_ff ? rd_data_ff[CODE_W+LEN_W-1:LEN_W] : '0;
   assign rd_length = rd_hit_ff ? rd_data_ff[LEN_W-1:0] : '0;

endmodule

// ----- rtl/hbp_packer.sv -----
module hbp_packer import hbp_pkg::*; #(
   parameter int CODE_W = 32,
   parameter int LEN_W  = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_fire,
   input  logic [CMD_BITS-1:0]  in_cmd,
   output logic                 in_ready,
   input  logic [CODE_W-1:0]    code,
   input  logic [LEN_W-1:0]     code_len,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BYTE_BITS-1:0] rsp_byte,
   output logic                 rsp_is_pad,
   output logic                 rsp_last
);

   localparam int ACC_W = CODE_W + BYTE_BITS;
   localparam int TOT_W = $clog2(ACC_W + 1);
   localparam logic [TOT_W-1:0] TOT_BYTE = TOT_W'(BYTE_BITS);

   typedef enum logic [1:0] {
      MODE_PACK,
      MODE_FIN_DATA,
      MODE_FIN_PAD
   } mode_type;

   mode_type              mode_ff, mode_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [TOT_W-1:0]      total_ff, total_in;
   logic                  s1_valid_ff;
   logic [CMD_BITS-1:0]   s1_cmd_ff;
   logic                  rsp_valid_ff;
   logic [BYTE_BITS-1:0]  rsp_byte_ff;
   logic                  rsp_is_pad_ff;
   logic                  rsp_last_ff;

   logic                  out_free;
   logic                  emit;
   logic                  absorb_ok;
   logic                  s1_take;
   logic [TOT_W-1:0]      rem;
   logic [BYTE_BITS-1:0]  pend;
   logic [BYTE_BITS-1:0]  fin_bits;
   logic [3:0]            pad;
   logic [BYTE_BITS-1:0]  emit_byte;
   logic                  emit_pad;
   logic                  emit_last;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fin_bits = acc_ff[BYTE_BITS-1:0] & ~(8'hFF << total_ff);
   assign pad      = 4'(BYTE_BITS) - total_ff[3:0];

   always_comb begin
      emit      = 1'b0;
      absorb_ok = 1'b0;
      rem       = total_ff;
      emit_byte = '0;
      emit_pad  = 1'b0;
      emit_last = 1'b0;
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      unique case (mode_ff)
         MODE_PACK: begin
            emit = (total_ff > TOT_BYTE) && out_free;
            if (emit) begin
               rem = total_ff - TOT_BYTE;
            end
            emit_byte = BYTE_BITS'(acc_ff >> (total_ff - TOT_BYTE));
            emit_last = (rem <= TOT_BYTE);
            absorb_ok = (rem <= TOT_BYTE);
         end
         MODE_FIN_DATA: begin
            emit      = out_free;
            emit_byte = BYTE_BITS'(fin_bits << pad);
            if (emit) begin
               mode_in = MODE_FIN_PAD;
            end
         end
         MODE_FIN_PAD: begin
            emit      = out_free;
            emit_byte = BYTE_BITS'(pad);
            emit_pad  = 1'b1;
            emit_last = 1'b1;
            if (emit) begin
               rem     = '0;
               mode_in = MODE_PACK;
            end
            absorb_ok = emit;
         end
         default: begin
            mode_in = MODE_PACK;
         end
      endcase

      s1_take  = s1_valid_ff && absorb_ok;
      pend     = acc_ff[BYTE_BITS-1:0] & ~(8'hFF << rem);
      total_in = rem;
      if (mode_ff == MODE_FIN_DATA) begin
         total_in = total_ff;
      end

      if (s1_take) begin
         unique case (s1_cmd_ff)
            CMD_ENCODE: begin
               acc_in   = (ACC_W'(pend) << code_len) | ACC_W'(code);
               total_in = rem + TOT_W'(code_len);
            end
            CMD_FINISH: begin
               acc_in   = ACC_W'(pend);
               total_in = rem;
               mode_in  = MODE_FIN_DATA;
            end
            default: begin
            end
         endcase
      end
   end

   assign in_ready = !s1_valid_ff || s1_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_PACK;
         total_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         total_ff <= total_in;
         if (in_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_take) begin
            s1_valid_ff <= 1'b0;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      acc_ff <= acc_in;
      if (in_fire) begin
         s1_cmd_ff <= in_cmd;
      end
      if (emit) begin
         rsp_byte_ff   <= emit_byte;
         rsp_is_pad_ff <= emit_pad;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_byte   = rsp_byte_ff;
   assign rsp_is_pad = rsp_is_pad_ff;
   assign rsp_last   = rsp_last_ff;

   a_fin_fits: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_PACK) |-> (total_ff <= TOT_BYTE))
      else $error("finish with more than one byte pending");

   a_pad_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_is_pad_ff) |-> rsp_last_ff)
      else $error("pad count byte not marked last");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !in_ready) |=> s1_valid_ff)
      else $error("stalled request dropped");

   a_fin_order: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_FIN_DATA && emit) |=>
      (mode_ff == MODE_FIN_PAD && rsp_valid_ff && !rsp_is_pad_ff))
      else $error("finish data byte not followed by pad phase");

endmodule

// ----- rtl/huffman_bit_packer.sv -----
// A request that yields bytes is registered with its table read, then absorbed into
// the bit buffer; bytes leave one per cycle from the result register unless stalled.
// Throughput: one request per cycle while no data or finish bytes are left to send.
// Reset: synchronous, active high; clears all code table valid bits at once (every
// symbol reads as an empty code) and empties the bit buffer. No clearing pass.
module huffman_bit_packer import hbp_pkg::*; #(
   parameter int MAX_CODE_LEN = 32,
   parameter int SYMBOL_COUNT = 256
) (
   input  logic         clock,
   input  logic         reset,
   hbp_stream_if.sink   req_ch,
   hbp_stream_if.source rsp_ch
);

   localparam int LIM    = (MAX_CODE_LEN > CODE_BITS) ? CODE_BITS : MAX_CODE_LEN;
   localparam int LEN_W  = $clog2(LIM + 1);
   localparam int ADDR_W = $clog2(SYMBOL_COUNT);

   tbl_ctrl_type      tbl_ctrl;
   logic              req_fire;
   logic              pk_ready;
   logic [LEN_W-1:0]  sat_len;
   logic [LIM-1:0]    masked_value;
   logic [LIM-1:0]    rd_value;
   logic [LEN_W-1:0]  rd_length;

   assign req_fire = req_ch.valid && pk_ready;
   assign req_ch.ready = pk_ready;

   assign sat_len = (req_ch.payload.code_length > LENGTH_BITS'(LIM)) ?
                    LEN_W'(LIM) : req_ch.payload.code_length[LEN_W-1:0];
   assign masked_value = req_ch.payload.code_value[LIM-1:0] & ~({LIM{1'b1}} << sat_len);

   assign tbl_ctrl.rd_en    = req_fire && (req_ch.payload.cmd == CMD_ENCODE);
   assign tbl_ctrl.wr_en    = req_fire && (req_ch.payload.cmd == CMD_LOAD);
   assign tbl_ctrl.in_range = {1'b0, req_ch.payload.symbol} < 9'(SYMBOL_COUNT);

   hbp_code_table #(
      .DEPTH (SYMBOL_COUNT),
      .ADDR_W(ADDR_W),
      .CODE_W(LIM),
      .LEN_W (LEN_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (tbl_ctrl),
      .addr     (req_ch.payload.symbol[ADDR_W-1:0]),
      .wr_value (masked_value),
      .wr_length(sat_len),
      .rd_value (rd_value),
      .rd_length(rd_length)
   );

   hbp_packer #(
      .CODE_W(LIM),
      .LEN_W (LEN_W)
   ) u_packer (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (req_fire),
      .in_cmd    (req_ch.payload.cmd),
      .in_ready  (pk_ready),
      .code      (rd_value),
      .code_len  (rd_length),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_byte  (rsp_ch.payload.out_byte),
      .rsp_is_pad(rsp_ch.payload.is_pad_count),
      .rsp_last  (rsp_ch.payload.last)
   );

endmodule

// ----- dv/hbp_byte_stream_checker.sv -----
module hbp_byte_stream_checker import hbp_pkg::*; #(
   parameter int MAX_CODE_LEN = 32,
   parameter int SYMBOL_COUNT = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   output int              mismatches,
   output int              bytes_waiting,
   output int              bytes_checked
);

   localparam int LENGTH_LIMIT = (MAX_CODE_LEN > CODE_BITS) ? CODE_BITS : MAX_CODE_LEN;

   logic [CODE_BITS-1:0]   code_word [SYMBOL_COUNT];
   logic [LENGTH_BITS-1:0] code_len  [SYMBOL_COUNT];
   logic [BYTE_BITS-1:0]   held_bits;
   int                     held_count;
   rsp_payload_type        expected_bytes [$];
   int                     err_count;
   int                     seen_count;

   // Bit buffer model: bytes leave only while more than eight bits are held.
   task automatic pack_code_bits(input req_payload_type p);
      int              len;
      int              total;
      int              n_out;
      int              pad;
      logic [63:0]     acc;
      logic [63:0]     mask;
      rsp_payload_type r;
      case (p.cmd)
         CMD_LOAD: begin
            len = int'(p.code_length);
            if (len > LENGTH_LIMIT) len = LENGTH_LIMIT;
            if (int'(p.symbol) < SYMBOL_COUNT) begin
               mask = (len >= 64) ? '1 : ((64'd1 << len) - 64'd1);
               code_word[p.symbol] = CODE_BITS'(64'(p.code_value) & mask);
               code_len[p.symbol]  = LENGTH_BITS'(len);
            end
         end
         CMD_ENCODE: begin
            len = 0;
            acc = '0;
            if (int'(p.symbol) < SYMBOL_COUNT) begin
               len = int'(code_len[p.symbol]);
               acc = 64'(code_word[p.symbol]);
            end
            acc   = (64'(held_bits) << len) | acc;
            total = held_count + len;
            n_out = (total > BYTE_BITS) ? (total - 1) / BYTE_BITS : 0;
            for (int k = 1; k <= n_out; k++) begin
               r.out_byte     = BYTE_BITS'(acc >> (total - BYTE_BITS));
               r.is_pad_count = 1'b0;
               r.last         = (k == n_out);
               expected_bytes.insert(expected_bytes.size(), r);
               total -= BYTE_BITS;
            end
            held_bits  = BYTE_BITS'(acc & ((64'd1 << total) - 64'd1));
            held_count = total;
         end
         CMD_FINISH: begin
            pad            = BYTE_BITS - held_count;
            r.out_byte     = BYTE_BITS'(16'(held_bits) << pad);
            r.is_pad_count = 1'b0;
            r.last         = 1'b0;
            expected_bytes.insert(expected_bytes.size(), r);
            r.out_byte     = BYTE_BITS'(pad);
            r.is_pad_count = 1'b1;
            r.last         = 1'b1;
            expected_bytes.insert(expected_bytes.size(), r);
            held_bits  = '0;
            held_count = 0;
         end
         default: ;
      endcase
   endtask

   task automatic compare_byte(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_bytes.size() == 0) begin
         $display("%0t unexpected byte: expected none, got %02h pad=%0b last=%0b",
                  $time, got.out_byte, got.is_pad_count, got.last);
         err_count++;
      end else begin
         want = expected_bytes.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $display("%0t out_byte mismatch: expected %02h, got %02h",
                     $time, want.out_byte, got.out_byte);
            err_count++;
         end
         if (got.is_pad_count !== want.is_pad_count) begin
            $display("%0t is_pad_count mismatch: expected %0b, got %0b",
                     $time, want.is_pad_count, got.is_pad_count);
            err_count++;
         end
         if (got.last !== want.last) begin
            $display("%0t last mismatch: expected %0b, got %0b",
                     $time, want.last, got.last);
            err_count++;
         end
      end
      seen_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SYMBOL_COUNT; s++) begin
            code_word[s] = '0;
            code_len[s]  = '0;
         end
         held_bits  = '0;
         held_count = 0;
         expected_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) compare_byte(rsp_payload);
         if (req_valid && req_ready) pack_code_bits(req_payload);
      end
      mismatches    <= err_count;
      bytes_waiting <= expected_bytes.size();
      bytes_checked <= seen_count;
   end

endmodule

// ----- dv/huffman_bit_packer_tb.sv -----
module huffman_bit_packer_tb;
   import hbp_pkg::*;

   localparam int          MAX_CODE_LEN  = 32;
   localparam int          SYMBOL_COUNT  = 256;
   localparam int          ITEM_TARGET   = 430;
   localparam int          IDLE_LIMIT    = 4000;
   localparam int          TAIL_CYCLES   = 12;
   localparam logic [1:0]  CMD_RESERVED  = 2'd3;

   logic            clock;
   logic            reset         = 1'b1;
   logic            req_valid_q   = 1'b0;
   req_payload_type req_payload_q = '0;
   logic            rsp_ready_q   = 1'b0;

   hbp_stream_if #(.payload_type(req_payload_type)) req_ch ();
   hbp_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   assign req_ch.valid   = req_valid_q;
   assign req_ch.payload = req_payload_q;
   assign rsp_ch.ready   = rsp_ready_q;

   int mismatches;
   int bytes_waiting;
   int bytes_checked;
   int requests_sent;
   int streams_closed;
   int burst_left;
   int idle_cycles;
   int stall_phase;
   int stall_mode;
   logic [7:0] stall_mask;
   logic [7:0] loaded_syms [$];

   huffman_bit_packer #(
      .MAX_CODE_LEN(MAX_CODE_LEN),
      .SYMBOL_COUNT(SYMBOL_COUNT)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   hbp_byte_stream_checker #(
      .MAX_CODE_LEN(MAX_CODE_LEN),
      .SYMBOL_COUNT(SYMBOL_COUNT)
   ) checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_ch.valid),
      .req_ready    (req_ch.ready),
      .req_payload  (req_ch.payload),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .rsp_payload  (rsp_ch.payload),
      .mismatches   (mismatches),
      .bytes_waiting(bytes_waiting),
      .bytes_checked(bytes_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: phases of always-ready, coin-flip, sparse and a rotating mask
   always @(posedge clock) begin
      if (stall_phase == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_mask <= 8'($urandom) | 8'h01;
      end else if (stall_mode == 3) begin
         stall_mask <= {stall_mask[6:0], stall_mask[7]};
      end
      stall_phase <= (stall_phase == 127) ? 0 : stall_phase + 1;
      case (stall_mode)
         0: rsp_ready_q <= 1'b1;
         1: rsp_ready_q <= 1'($urandom);
         2: rsp_ready_q <= ($urandom_range(0, 3) == 0);
         default: rsp_ready_q <= stall_mask[0];
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no request or byte accepted for %0d cycles", IDLE_LIMIT);
         $display("huffman_bit_packer_tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic issue(input logic [1:0] cmd, input logic [7:0] sym,
                        input logic [31:0] val, input logic [5:0] len);
      req_payload_type p;
      int gap;
      p.cmd         = cmd;
      p.symbol      = sym;
      p.code_value  = val;
      p.code_length = len;
      req_valid_q   <= 1'b1;
      req_payload_q <= p;
      do @(posedge clock); while (!req_ch.ready);
      if (cmd != CMD_RESERVED) requests_sent++;
      if (cmd == CMD_FINISH) streams_closed++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid_q <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic logic [5:0] pick_length();
      int k;
      k = $urandom_range(0, 9);
      if (k < 7) return 6'($urandom_range(1, 12));
      if (k < 9) return 6'($urandom_range(13, 32));
      return 6'($urandom_range(0, 63));
   endfunction

   initial begin
      int n;
      int k;
      logic [7:0] sym;
      burst_left = $urandom_range(1, 24);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      issue(CMD_FINISH, 8'h00, 32'h0, 6'd0);               // empty buffer
      issue(CMD_ENCODE, 8'h00, 32'hFFFFFFFF, 6'd63);       // never loaded
      issue(CMD_LOAD, 8'hFF, 32'hFFFFFFFF, 6'd32);
      issue(CMD_LOAD, 8'h00, 32'h000000A5, 6'd8);
      issue(CMD_LOAD, 8'h01, 32'hDEADBEEF, 6'd63);         // saturates
      issue(CMD_LOAD, 8'h02, 32'hFFFFFFFF, 6'd3);          // upper bits dropped
      issue(CMD_LOAD, 8'h03, 32'h12345678, 6'd0);          // empty code
      issue(CMD_RESERVED, 8'h00, 32'hFFFFFFFF, 6'd5);
      issue(CMD_ENCODE, 8'h00, 32'h0, 6'd0);               // exactly eight held
      issue(CMD_FINISH, 8'hFF, 32'hFFFFFFFF, 6'd63);       // pad count zero
      issue(CMD_ENCODE, 8'hFF, 32'h0, 6'd0);
      issue(CMD_ENCODE, 8'h02, 32'h0, 6'd0);
      issue(CMD_ENCODE, 8'h01, 32'h0, 6'd0);               // four bytes out
      issue(CMD_ENCODE, 8'h03, 32'h0, 6'd0);
      issue(CMD_FINISH, 8'h00, 32'h0, 6'd0);
      issue(CMD_LOAD, 8'h80, 32'h00000001, 6'd1);
      issue(CMD_ENCODE, 8'h80, 32'h0, 6'd0);
      issue(CMD_ENCODE, 8'h80, 32'h0, 6'd0);
      issue(CMD_FINISH, 8'h00, 32'h0, 6'd0);

      while (requests_sent < ITEM_TARGET) begin
         if (loaded_syms.size() == 0 || $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) begin
               sym = 8'($urandom);
               issue(CMD_LOAD, sym, $urandom, pick_length());
               loaded_syms.insert(loaded_syms.size(), sym);
               if (loaded_syms.size() > 32) void'(loaded_syms.pop_front());
            end
         end
         n = $urandom_range(1, 16);
         repeat (n) begin
            k = $urandom_range(0, 9);
            if (k == 0) sym = 8'($urandom);
            else sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
            if (k == 1) issue(CMD_RESERVED, 8'($urandom), $urandom, 6'($urandom));
            issue(CMD_ENCODE, sym, $urandom, 6'($urandom));
         end
         if ($urandom_range(0, 4) != 0) issue(CMD_FINISH, 8'($urandom), $urandom, 6'($urandom));
      end
      issue(CMD_FINISH, 8'($urandom), $urandom, 6'($urandom));

      req_valid_q <= 1'b0;
      @(posedge clock);
      while (bytes_waiting != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d requests over %0d finished streams, %0d output bytes checked",
               requests_sent, streams_closed, bytes_checked);
      if (mismatches == 0 && bytes_waiting == 0) begin
         $display("huffman_bit_packer_tb: clean");
      end else begin
         $display("huffman_bit_packer_tb: errors");
      end
      $finish;
   end

endmodule
